>>> hdl/tccw_pkg.sv
// Package for the text console cell writer: field widths, character codes,
// the microcode word and the microcode ROM. It depends on nothing else.
package tccw_pkg;

   localparam int COLUMNS_DEF  = 80;
   localparam int ROWS_DEF     = 25;
   localparam int TAB_STOP_DEF = 8;

   localparam int CHAR_W        = 8;
   localparam int ATTR_W        = 8;
   localparam int COL_W         = 7;
   localparam int ROW_W         = 5;
   localparam int INDEX_W       = 11;
   localparam int INDEX_FULL_W  = COL_W + ROW_W;
   localparam int WORD_W        = 16;
   localparam int PHASE_W       = 3;
   localparam int COUNT_W       = 4;
   localparam int STEP_W        = 3;

   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_FETCH     = 3'd0;
   localparam step_type STEP_TAB       = 3'd1;
   localparam step_type STEP_NEWLINE   = 3'd2;
   localparam step_type STEP_BACKSPACE = 3'd3;
   localparam step_type STEP_BLANK     = 3'd4;
   localparam step_type STEP_PRINT     = 3'd5;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_ADVANCE,
      CUR_NEXT_LINE,
      CUR_RETREAT
   } cursor_op_type;

   typedef enum logic [1:0] {
      JMP_FETCH,
      JMP_REPEAT,
      JMP_NEXT,
      JMP_GOTO
   } jump_type;

   typedef struct packed {
      logic          emit;
      logic          use_char;
      logic          last_on_count;
      logic          dec_count;
      cursor_op_type cursor_op;
      jump_type      jump;
      step_type      target;
   } uword_type;

   typedef struct packed {
      logic     accept;
      logic     fire;
      logic     more;
      step_type dispatch;
   } seq_status_type;

   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = '{emit: 1'b0, use_char: 1'b0, last_on_count: 1'b0, dec_count: 1'b0,
            cursor_op: CUR_HOLD, jump: JMP_GOTO, target: STEP_FETCH};
      case (step)
         STEP_FETCH: begin
            w.jump = JMP_FETCH;
         end
         STEP_TAB: begin
            w.emit          = 1'b1;
            w.last_on_count = 1'b1;
            w.dec_count     = 1'b1;
            w.cursor_op     = CUR_ADVANCE;
            w.jump          = JMP_REPEAT;
            w.target        = STEP_TAB;
         end
         STEP_NEWLINE: begin
            w.cursor_op = CUR_NEXT_LINE;
         end
         STEP_BACKSPACE: begin
            w.cursor_op = CUR_RETREAT;
            w.jump      = JMP_NEXT;
         end
         STEP_BLANK: begin
            w.emit = 1'b1;
         end
         STEP_PRINT: begin
            w.emit      = 1'b1;
            w.use_char  = 1'b1;
            w.cursor_op = CUR_ADVANCE;
         end
         default: begin
            w.jump = JMP_GOTO;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hdl/tccw_req_if.sv
// Input channel of the text console cell writer: one character code per item.
// Depends on tccw_pkg.
interface tccw_req_if;
   logic                        valid;
   logic                        ready;
   logic [tccw_pkg::CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

>>> hdl/tccw_rsp_if.sv
// Result channel of the text console cell writer: one written cell per item.
// Depends on tccw_pkg.
interface tccw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tccw_pkg::INDEX_W-1:0] cell_index;
   logic [tccw_pkg::WORD_W-1:0]  cell_word;
   logic                         last_write;

   modport source (output valid, output cell_index, output cell_word, output last_write,
                   input ready);
   modport sink (input valid, input cell_index, input cell_word, input last_write,
                 output ready);
endinterface

>>> hdl/tccw_csr_if.sv
// Configuration write channel of the text console cell writer: the attribute byte.
// Depends on tccw_pkg.
interface tccw_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tccw_pkg::ATTR_W-1:0] text_attribute;

   modport source (output valid, output text_attribute, input ready);
   modport sink (input valid, input text_attribute, output ready);
endinterface

>>> hdl/tccw_seq.sv
// Microcode sequencer of the text console cell writer: step counter, ROM and jumps.
// Depends on tccw_pkg.
module tccw_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  tccw_pkg::seq_status_type status,
   output tccw_pkg::uword_type      uword,
   output logic                     fetching
);

   tccw_pkg::step_type step_ff;
   tccw_pkg::step_type step_in;

   assign uword    = tccw_pkg::ucode_rom(step_ff);
   assign fetching = (uword.jump == tccw_pkg::JMP_FETCH);

   always_comb begin
      step_in = step_ff;
      case (uword.jump)
         tccw_pkg::JMP_FETCH: begin
            if (status.accept) step_in = status.dispatch;
         end
         tccw_pkg::JMP_REPEAT: begin
            if (status.fire) step_in = status.more ? uword.target : tccw_pkg::STEP_FETCH;
         end
         tccw_pkg::JMP_NEXT: begin
            if (status.fire) step_in = step_ff + 3'd1;
         end
         tccw_pkg::JMP_GOTO: begin
            if (status.fire) step_in = uword.target;
         end
         default: begin
            step_in = tccw_pkg::STEP_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= tccw_pkg::STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> hdl/text_console_cell_writer.sv
// Top level of the text console cell writer: cursor datapath, result register
// and configuration register. Depends on tccw_pkg, the three channel interfaces
// and tccw_seq.
//
// Usage: req_chan carries one character code per item. Each item produces zero
// or more cell writes on rsp_chan, each with the cell index (row times columns
// plus column) and the cell word (attribute high, character low); last_write
// marks the final write of an item. A newline produces no result, a printable
// byte or a backspace one, and a tab one to TAB_STOP spaces.
// csr_chan writes the attribute byte and is always ready.
// The first result is registered from the first write step of an item, which
// directly follows the fetch step, or the retreat step for a backspace.
// An item takes a fetch step plus a print or newline step, a retreat and a blank
// step for a backspace, or a write step per space for a tab. The sequencer runs
// one step per cycle unless a write stalls, with at most one cell write per step.
// Reset puts the cursor at row 0, column 0 and the attribute at 7.
// When the receiver stalls, the pending result is held in the output register
// and the sequencer waits at its next write step; steps that write nothing, the fetch step included, go on.
module text_console_cell_writer #(
   parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
   parameter int ROWS     = tccw_pkg::ROWS_DEF,
   parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tccw_req_if.sink   req_chan,
   tccw_rsp_if.source rsp_chan,
   tccw_csr_if.sink   csr_chan
);

   localparam logic [tccw_pkg::COL_W-1:0]   LAST_COL   = tccw_pkg::COL_W'(COLUMNS - 1);
   localparam logic [tccw_pkg::ROW_W-1:0]   LAST_ROW   = tccw_pkg::ROW_W'(ROWS - 1);
   localparam logic [tccw_pkg::PHASE_W-1:0] LAST_PHASE = tccw_pkg::PHASE_W'(TAB_STOP - 1);
   localparam logic [tccw_pkg::PHASE_W-1:0] END_PHASE  =
      tccw_pkg::PHASE_W'((COLUMNS - 1) % TAB_STOP);
   localparam logic [tccw_pkg::COUNT_W-1:0] TAB_COUNT  = tccw_pkg::COUNT_W'(TAB_STOP);

   tccw_pkg::uword_type      uword;
   tccw_pkg::seq_status_type status;
   logic                     fetching;
   logic                     out_free;
   logic                     last;

   logic [tccw_pkg::ATTR_W-1:0]       attr_ff;
   logic [tccw_pkg::CHAR_W-1:0]       char_ff;
   logic [tccw_pkg::COL_W-1:0]        col_ff, col_in;
   logic [tccw_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [tccw_pkg::PHASE_W-1:0]      phase_ff, phase_in;
   logic [tccw_pkg::COUNT_W-1:0]      count_ff;
   logic [tccw_pkg::INDEX_FULL_W-1:0] index_full;
   logic                              rsp_valid_ff;
   logic [tccw_pkg::INDEX_W-1:0]      rsp_index_ff;
   logic [tccw_pkg::WORD_W-1:0]       rsp_word_ff;
   logic                              rsp_last_ff;

   tccw_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .uword    (uword),
      .fetching (fetching)
   );

   assign req_chan.ready = fetching;
   assign csr_chan.ready = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      status.accept = req_chan.valid && req_chan.ready;
      status.fire   = !uword.emit || out_free;
      status.more   = (count_ff > 4'd1);
      case (req_chan.char_code)
         tccw_pkg::CH_TAB:       status.dispatch = tccw_pkg::STEP_TAB;
         tccw_pkg::CH_NEWLINE:   status.dispatch = tccw_pkg::STEP_NEWLINE;
         tccw_pkg::CH_BACKSPACE: status.dispatch = tccw_pkg::STEP_BACKSPACE;
         default:                status.dispatch = tccw_pkg::STEP_PRINT;
      endcase
   end

   assign index_full = tccw_pkg::INDEX_FULL_W'(row_ff) * tccw_pkg::INDEX_FULL_W'(COLUMNS)
                     + tccw_pkg::INDEX_FULL_W'(col_ff);
   assign last       = uword.last_on_count ? (count_ff == 4'd1) : 1'b1;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      case (uword.cursor_op)
         tccw_pkg::CUR_HOLD: begin
            col_in = col_ff;
         end
         tccw_pkg::CUR_ADVANCE: begin
            if (col_ff == LAST_COL) begin
               col_in   = '0;
               phase_in = '0;
               row_in   = (row_ff == LAST_ROW) ? '0 : row_ff + 5'd1;
            end else begin
               col_in   = col_ff + 7'd1;
               phase_in = (phase_ff == LAST_PHASE) ? '0 : phase_ff + 3'd1;
            end
         end
         tccw_pkg::CUR_NEXT_LINE: begin
            col_in   = '0;
            phase_in = '0;
            row_in   = (row_ff == LAST_ROW) ? '0 : row_ff + 5'd1;
         end
         tccw_pkg::CUR_RETREAT: begin
            if (col_ff == '0) begin
               col_in   = LAST_COL;
               phase_in = END_PHASE;
               row_in   = (row_ff == '0) ? LAST_ROW : row_ff - 5'd1;
            end else begin
               col_in   = col_ff - 7'd1;
               phase_in = (phase_ff == '0) ? LAST_PHASE : phase_ff - 3'd1;
            end
         end
         default: begin
            col_in = col_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tccw_pkg::ATTR_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) attr_ff <= csr_chan.text_attribute;
         if (status.accept) begin
            count_ff <= TAB_COUNT - tccw_pkg::COUNT_W'(phase_ff);
         end else if (status.fire && uword.dec_count) begin
            count_ff <= count_ff - 4'd1;
         end
         if (status.fire) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            phase_ff <= phase_in;
         end
         if (status.fire && uword.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (status.accept) char_ff <= req_chan.char_code;
      if (status.fire && uword.emit) begin
         rsp_index_ff <= index_full[tccw_pkg::INDEX_W-1:0];
         rsp_word_ff  <= {attr_ff, uword.use_char ? char_ff : tccw_pkg::CH_SPACE};
         rsp_last_ff  <= last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_index = rsp_index_ff;
   assign rsp_chan.cell_word  = rsp_word_ff;
   assign rsp_chan.last_write = rsp_last_ff;

   // The cursor always stays on the screen.
   assert property (@(posedge clock) disable iff (reset)
      (col_ff <= LAST_COL) && (row_ff <= LAST_ROW))
      else $error("cursor outside the screen");

   // The tab phase restarts at every line start.
   assert property (@(posedge clock) disable iff (reset)
      (col_ff == '0) |-> (phase_ff == '0))
      else $error("tab phase not zero at column zero");

   // A counted write step always has spaces left to write.
   assert property (@(posedge clock) disable iff (reset)
      uword.dec_count |-> (count_ff != '0) && (count_ff <= TAB_COUNT))
      else $error("tab count out of range");

   // A new item is only taken once the last write of the previous one is issued.
   assert property (@(posedge clock) disable iff (reset)
      (status.accept && rsp_valid_ff) |-> rsp_last_ff)
      else $error("item accepted while its predecessor still writes");

endmodule
